// ===== hdl/lpht_pkg.sv =====
// Shared widths, codes, types and the helper function of the linear probe hash table.
package lpht_pkg;

    // Field widths of the request, response and configuration items.
    localparam int OP_W       = 2;
    localparam int HASH_W     = 32;
    localparam int VALUE_W    = 64;
    localparam int INDEX_W    = 10;
    localparam int TSIZE_W    = 11;
    localparam int EBYTES_W   = 4;

    // Default number of physical slots.
    localparam int SLOT_COUNT_DEF = 1024;

    // Configuration port layout.
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int REG_SEL_BIT = 2;
    localparam logic REG_TABLE_SIZE  = 1'b0;
    localparam logic REG_ENTRY_BYTES = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [TSIZE_W-1:0]  TSIZE_RESET  = 11'd1024;
    localparam logic [EBYTES_W-1:0] EBYTES_RESET = 4'd8;

    // Bytes in one stored value.
    localparam int VALUE_BYTES = VALUE_W / 8;

    // Modulo unit: dividend bits retired per cycle, and steps per request.
    localparam int MOD_STEP_BITS = 4;
    localparam int MOD_STEPS     = HASH_W / MOD_STEP_BITS;

    // Request operations.
    typedef enum logic [OP_W-1:0] {
        OP_FIND   = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2
    } op_t;

    // Slot flags.
    typedef enum logic [1:0] {
        FLAG_EMPTY    = 2'd0,
        FLAG_DELETED  = 2'd1,
        FLAG_OCCUPIED = 2'd2
    } flag_t;

    // Engine sequencer states.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_PROBE,
        S_UPDATE,
        S_DONE
    } state_t;

    // One slot word of the flag and hash memory.
    typedef struct packed {
        flag_t               flag;
        logic [HASH_W-1:0]   hash;
    } slot_t;

    // Configuration seen by the engine.
    typedef struct packed {
        logic [TSIZE_W-1:0]  table_size;
        logic [EBYTES_W-1:0] entry_bytes;
    } cfg_t;

    // One request as handed to the engine.
    typedef struct packed {
        op_t                 op;
        logic [HASH_W-1:0]   key_hash;
        logic [VALUE_W-1:0]  value_word;
        logic [INDEX_W-1:0]  slot_index;
    } req_t;

    // One response as produced by the engine.
    typedef struct packed {
        logic                found;
        logic [INDEX_W-1:0]  result_index;
        logic                accepted;
    } res_t;

    // Mask that keeps the low entry_bytes bytes of a value; zero acts as one,
    // anything from a full word up keeps the whole word.
    function automatic logic [VALUE_W-1:0] value_mask(input logic [EBYTES_W-1:0] eb);
        logic [EBYTES_W-1:0] b;
        logic [VALUE_W-1:0]  m;
        b = (eb == '0) ? EBYTES_W'(1) : eb;
        if (b >= EBYTES_W'(VALUE_BYTES)) begin
            m = '1;
        end
        else begin
            m = (VALUE_W'(1) << {b[2:0], 3'b000}) - VALUE_W'(1);
        end
        return m;
    endfunction

endpackage

// ===== hdl/lpht_req_if.sv =====
// Request channel interface of the linear probe hash table.
interface lpht_req_if;
    logic                              valid;
    logic                              ready;
    logic [lpht_pkg::OP_W-1:0]         operation;
    logic [lpht_pkg::HASH_W-1:0]       key_hash;
    logic [lpht_pkg::VALUE_W-1:0]      value_word;
    logic [lpht_pkg::INDEX_W-1:0]      slot_index;

    modport source (
        output valid, operation, key_hash, value_word, slot_index,
        input  ready
    );

    modport sink (
        input  valid, operation, key_hash, value_word, slot_index,
        output ready
    );
endinterface

// ===== hdl/lpht_rsp_if.sv =====
// Response channel interface of the linear probe hash table.
interface lpht_rsp_if;
    logic                              valid;
    logic                              ready;
    logic                              found;
    logic [lpht_pkg::INDEX_W-1:0]      result_index;
    logic                              accepted;

    modport source (
        output valid, found, result_index, accepted,
        input  ready
    );

    modport sink (
        input  valid, found, result_index, accepted,
        output ready
    );
endinterface

// ===== hdl/linear_probe_hash_table_top.sv =====
// Top level of the linear probe hash table: channels, configuration port, response register.
//
// Requests enter on the req channel (valid/ready) and carry an operation, a key
// hash, a value and a slot index. Each request yields exactly one response on
// the rsp channel: found, result_index and accepted.
// Find reduces the hash modulo table_size and reads the home slot, then probes
// one slot per cycle. Insert and remove read the slot and write it back; an
// insert into a full table or an out-of-range slot, or a remove of an
// out-of-range slot, responds without touching the memory.
// The engine handles one request at a time, so the probe chain length sets the rate.
// A response sits in an output register, so the engine takes the next request
// while the previous response still waits; if the receiver keeps ready low, the
// engine holds its next response until the register drains.
// After reset the block clears every slot flag, one slot per cycle, and keeps
// req.ready low meanwhile.
// Registers table_size (address 0) and entry_bytes (address 4) are written over
// the APB port and must only change while no request is in flight.
module linear_probe_hash_table_top #(
    parameter int SLOT_COUNT = lpht_pkg::SLOT_COUNT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    lpht_req_if.sink                        req,
    lpht_rsp_if.source                      rsp,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lpht_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [lpht_pkg::APB_DATA_W-1:0] pwdata,
    output logic [lpht_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import lpht_pkg::*;

    logic [TSIZE_W-1:0]  table_size_reg,  table_size_next;
    logic [EBYTES_W-1:0] entry_bytes_reg, entry_bytes_next;
    logic                cfg_we;

    logic                out_valid_reg,   out_valid_next;
    res_t                out_res_reg,     out_res_next;

    cfg_t                cfg;
    req_t                eng_req;
    res_t                eng_res;
    logic                eng_req_ready;
    logic                eng_res_valid;
    logic                eng_res_ready;

    // Configuration writes and reads.
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_comb
    begin
        table_size_next  = table_size_reg;
        entry_bytes_next = entry_bytes_reg;
        if (cfg_we)
        begin
            case (paddr[REG_SEL_BIT])
                REG_TABLE_SIZE:  table_size_next  = pwdata[TSIZE_W-1:0];
                REG_ENTRY_BYTES: entry_bytes_next = pwdata[EBYTES_W-1:0];
                default:         table_size_next  = table_size_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[REG_SEL_BIT])
            REG_TABLE_SIZE:  prdata = APB_DATA_W'(table_size_reg);
            REG_ENTRY_BYTES: prdata = APB_DATA_W'(entry_bytes_reg);
            default:         prdata = '0;
        endcase
    end

    assign cfg = '{table_size: table_size_reg, entry_bytes: entry_bytes_reg};

    // Request into the engine.
    assign eng_req = '{op: op_t'(req.operation), key_hash: req.key_hash,
                       value_word: req.value_word, slot_index: req.slot_index};
    assign req.ready = eng_req_ready;

    lpht_engine #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .req_valid (req.valid),
        .req_ready (eng_req_ready),
        .req       (eng_req),
        .res_valid (eng_res_valid),
        .res_ready (eng_res_ready),
        .res       (eng_res)
    );

    // Response register between the engine and the receiver.
    assign eng_res_ready = !out_valid_reg || rsp.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (eng_res_valid && eng_res_ready)
        begin
            out_valid_next = 1'b1;
            out_res_next   = eng_res;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg  <= TSIZE_RESET;
            entry_bytes_reg <= EBYTES_RESET;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            table_size_reg  <= table_size_next;
            entry_bytes_reg <= entry_bytes_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Response payload.
    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.found        = out_res_reg.found;
    assign rsp.result_index = out_res_reg.result_index;
    assign rsp.accepted     = out_res_reg.accepted;

endmodule

// ===== hdl/lpht_mod.sv =====
// Multi-cycle unit that reduces a 32-bit hash modulo the table size.
module lpht_mod #(
    parameter int DIV_W = 11
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [lpht_pkg::HASH_W-1:0] dividend,
    input  logic [DIV_W-1:0]            divisor,
    output logic                        done,
    output logic [DIV_W-1:0]            remainder
);
    import lpht_pkg::*;

    localparam int CNT_W = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;

    logic               busy_reg,  busy_next;
    logic               done_reg,  done_next;
    logic [CNT_W-1:0]   cnt_reg,   cnt_next;
    logic [HASH_W-1:0]  dvd_reg,   dvd_next;
    logic [DIV_W-1:0]   rem_reg,   rem_next;

    logic [HASH_W-1:0]  dvd_step;
    logic [DIV_W-1:0]   rem_step;
    logic [DIV_W:0]     trial;

    // Restoring reduction over MOD_STEP_BITS dividend bits per cycle.
    always_comb
    begin
        rem_step = rem_reg;
        dvd_step = dvd_reg;
        trial    = '0;
        for (int k = 0; k < MOD_STEP_BITS; k++)
        begin
            trial    = {rem_step, dvd_step[HASH_W-1]};
            dvd_step = dvd_step << 1;
            if (trial >= {1'b0, divisor})
            begin
                trial = trial - {1'b0, divisor};
            end
            rem_step = trial[DIV_W-1:0];
        end
    end

    // Sequencing of the reduction.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = dvd_step;
            rem_next = rem_step;
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(MOD_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Data registers.
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ===== hdl/lpht_engine.sv =====
// Table engine: slot memories, probe sequencer, insert and remove updates.
module lpht_engine #(
    parameter int SLOT_COUNT = lpht_pkg::SLOT_COUNT_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  lpht_pkg::cfg_t  cfg,
    input  logic            req_valid,
    output logic            req_ready,
    input  lpht_pkg::req_t  req,
    output logic            res_valid,
    input  logic            res_ready,
    output lpht_pkg::res_t  res
);
    import lpht_pkg::*;

    localparam int IW = $clog2(SLOT_COUNT);
    localparam int NW = $clog2(SLOT_COUNT + 1);
    localparam int CW = (NW > TSIZE_W) ? NW : TSIZE_W;

    // Slot memories.
    slot_t              slot_mem  [SLOT_COUNT];
    logic [VALUE_W-1:0] value_mem [SLOT_COUNT];

    logic               slot_we;
    logic [IW-1:0]      wr_addr;
    slot_t              wr_data;
    logic               value_we;
    logic [VALUE_W-1:0] value_wr_data;
    logic               rd_en;
    logic [IW-1:0]      rd_addr;
    slot_t              slot_rd_reg;

    // Sequencer and datapath registers.
    state_t             state_reg,     state_next;
    logic [IW-1:0]      clr_idx_reg,   clr_idx_next;
    logic [NW-1:0]      count_reg,     count_next;
    logic               have_tomb_reg, have_tomb_next;
    op_t                op_reg,        op_next;
    logic [HASH_W-1:0]  key_reg,       key_next;
    logic [VALUE_W-1:0] value_reg,     value_next;
    logic [IW-1:0]      slot_reg,      slot_next;
    logic [IW-1:0]      idx_reg,       idx_next;
    logic [IW-1:0]      home_reg,      home_next;
    logic [IW-1:0]      tomb_reg,      tomb_next;
    logic [NW-1:0]      probe_cnt_reg, probe_cnt_next;
    logic               found_reg,     found_next;
    logic [IW-1:0]      where_reg,     where_next;
    logic               accepted_reg,  accepted_next;

    // Modulo unit handshake.
    logic               mod_start;
    logic               mod_done;
    logic [CW-1:0]      mod_rem;

    // Derived values.
    logic [CW-1:0]      ts_ext;
    logic [CW-1:0]      n_used;
    logic [CW-1:0]      slot_ext;
    logic               slot_ok;
    logic               table_full;
    logic [IW-1:0]      idx_succ;
    logic               p_empty;
    logic               p_hit;
    logic               p_tomb;
    logic               p_lap;
    logic               tomb_seen;
    logic [IW-1:0]      tomb_idx;

    // Slots in use: zero acts as one, above the memory size acts as the memory size.
    assign ts_ext = CW'(cfg.table_size);
    assign n_used = (ts_ext == '0) ? CW'(1) :
                    (ts_ext > CW'(SLOT_COUNT)) ? CW'(SLOT_COUNT) : ts_ext;

    assign slot_ext   = CW'(req.slot_index);
    assign slot_ok    = slot_ext < n_used;
    assign table_full = CW'(count_reg) >= n_used;

    // Next probe position, wrapping at the table size.
    assign idx_succ = ((CW'(idx_reg) + CW'(1)) == n_used) ? '0 : idx_reg + IW'(1);

    // Probe classification of the slot read last cycle.
    assign p_empty   = slot_rd_reg.flag == FLAG_EMPTY;
    assign p_hit     = (slot_rd_reg.flag == FLAG_OCCUPIED) && (slot_rd_reg.hash == key_reg);
    assign p_tomb    = !p_empty && (slot_rd_reg.flag != FLAG_OCCUPIED);
    assign p_lap     = (CW'(probe_cnt_reg) + CW'(1)) == n_used;
    assign tomb_seen = have_tomb_reg || p_tomb;
    assign tomb_idx  = have_tomb_reg ? tomb_reg : idx_reg;

    lpht_mod #(
        .DIV_W (CW)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (req.key_hash),
        .divisor   (n_used),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_idx_reg == IW'(SLOT_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    case (req.op)
                        OP_FIND:   state_next = S_MOD;
                        OP_INSERT: state_next = (table_full || !slot_ok) ? S_DONE : S_UPDATE;
                        OP_REMOVE: state_next = slot_ok ? S_UPDATE : S_DONE;
                        default:   state_next = S_DONE;
                    endcase
                end
            end
            S_MOD:
            begin
                if (mod_done)
                begin
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (p_empty || p_hit || p_lap)
                begin
                    state_next = S_DONE;
                end
            end
            S_UPDATE:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Memory control and datapath updates.
    always_comb
    begin
        slot_we        = 1'b0;
        wr_addr        = clr_idx_reg;
        wr_data        = '{flag: FLAG_EMPTY, hash: '0};
        value_we       = 1'b0;
        value_wr_data  = value_reg & value_mask(cfg.entry_bytes);
        rd_en          = 1'b0;
        rd_addr        = idx_succ;
        mod_start      = 1'b0;
        clr_idx_next   = clr_idx_reg;
        count_next     = count_reg;
        have_tomb_next = have_tomb_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        value_next     = value_reg;
        slot_next      = slot_reg;
        idx_next       = idx_reg;
        home_next      = home_reg;
        tomb_next      = tomb_reg;
        probe_cnt_next = probe_cnt_reg;
        found_next     = found_reg;
        where_next     = where_reg;
        accepted_next  = accepted_reg;
        case (state_reg)
            S_CLEAR:
            begin
                // Clearing pass: one slot per cycle back to empty.
                slot_we      = 1'b1;
                clr_idx_next = clr_idx_reg + IW'(1);
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next       = req.op;
                    key_next      = req.key_hash;
                    value_next    = req.value_word;
                    slot_next     = slot_ext[IW-1:0];
                    found_next    = 1'b0;
                    where_next    = '0;
                    accepted_next = 1'b1;
                    case (req.op)
                        OP_FIND:
                        begin
                            mod_start      = 1'b1;
                            have_tomb_next = 1'b0;
                            probe_cnt_next = '0;
                        end
                        OP_INSERT:
                        begin
                            if (table_full || !slot_ok)
                            begin
                                accepted_next = 1'b0;
                            end
                            else
                            begin
                                rd_en   = 1'b1;
                                rd_addr = slot_ext[IW-1:0];
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (slot_ok)
                            begin
                                rd_en   = 1'b1;
                                rd_addr = slot_ext[IW-1:0];
                            end
                        end
                        default:
                        begin
                            accepted_next = 1'b0;
                        end
                    endcase
                end
            end
            S_MOD:
            begin
                // Home slot known: read it.
                if (mod_done)
                begin
                    idx_next  = mod_rem[IW-1:0];
                    home_next = mod_rem[IW-1:0];
                    rd_en     = 1'b1;
                    rd_addr   = mod_rem[IW-1:0];
                end
            end
            S_PROBE:
            begin
                // Read the following slot while the current one is checked.
                rd_en = 1'b1;
                if (p_empty)
                begin
                    found_next = 1'b0;
                    where_next = have_tomb_reg ? tomb_reg : idx_reg;
                end
                else if (p_hit)
                begin
                    found_next = 1'b1;
                    where_next = idx_reg;
                end
                else
                begin
                    if (p_tomb && !have_tomb_reg)
                    begin
                        have_tomb_next = 1'b1;
                        tomb_next      = idx_reg;
                    end
                    if (p_lap)
                    begin
                        found_next = 1'b0;
                        where_next = tomb_seen ? tomb_idx : home_reg;
                    end
                    else
                    begin
                        idx_next       = idx_succ;
                        probe_cnt_next = probe_cnt_reg + NW'(1);
                    end
                end
            end
            S_UPDATE:
            begin
                wr_addr = slot_reg;
                case (op_reg)
                    OP_INSERT:
                    begin
                        slot_we  = 1'b1;
                        wr_data  = '{flag: FLAG_OCCUPIED, hash: key_reg};
                        value_we = 1'b1;
                        if (slot_rd_reg.flag != FLAG_OCCUPIED)
                        begin
                            count_next = count_reg + NW'(1);
                        end
                    end
                    OP_REMOVE:
                    begin
                        slot_we = 1'b1;
                        wr_data = '{flag: FLAG_DELETED, hash: slot_rd_reg.hash};
                        if ((slot_rd_reg.flag == FLAG_OCCUPIED) && (count_reg != '0))
                        begin
                            count_next = count_reg - NW'(1);
                        end
                    end
                    default:
                    begin
                        slot_we = 1'b0;
                    end
                endcase
            end
            S_DONE:
            begin
                rd_en = 1'b0;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    // Flag and hash memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            slot_rd_reg <= slot_mem[rd_addr];
        end
    end

    // Value memory.
    always_ff @(posedge clk)
    begin
        if (value_we)
        begin
            value_mem[slot_reg] <= value_wr_data;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_idx_reg   <= '0;
            count_reg     <= '0;
            have_tomb_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            count_reg     <= count_next;
            have_tomb_reg <= have_tomb_next;
        end
    end

    // Data registers.
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        key_reg       <= key_next;
        value_reg     <= value_next;
        slot_reg      <= slot_next;
        idx_reg       <= idx_next;
        home_reg      <= home_next;
        tomb_reg      <= tomb_next;
        probe_cnt_reg <= probe_cnt_next;
        found_reg     <= found_next;
        where_reg     <= where_next;
        accepted_reg  <= accepted_next;
    end

    assign req_ready = state_reg == S_IDLE;
    assign res_valid = state_reg == S_DONE;
    assign res       = '{found: found_reg, result_index: INDEX_W'(where_reg),
                         accepted: accepted_reg};

    // The entry count never passes the number of physical slots.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= NW'(SLOT_COUNT))
        else $error("entry count above slot count");

    // A find never writes the slot memory.
    a_probe_read_only: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PROBE) |-> !slot_we)
        else $error("slot memory written during probe");

    // A probe never runs past one full lap.
    a_probe_lap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PROBE) |-> (CW'(probe_cnt_reg) < n_used))
        else $error("probe ran past a full lap");

    // A hit is only reported together with accepted.
    a_found_accepted: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && found_reg) |-> accepted_reg)
        else $error("found without accepted");

    // The modulo unit only finishes while the sequencer waits for it.
    a_mod_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        mod_done |-> (state_reg == S_MOD))
        else $error("modulo result outside its wait state");

endmodule
